>>> rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// shared types, codes and constants for the rational arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAG_W          = 64;
    localparam int PROD_W         = 66;
    localparam int MUL_W          = 33;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_NEG = 3'd4;
    localparam logic [2:0] OP_RED = 3'd5;
    localparam logic [2:0] OP_CMP = 3'd6;
    localparam logic [2:0] OP_NOP = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } rau_in_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               is_less;
        logic               is_equal;
        logic [1:0]         status;
    } rau_out_t;

endpackage

`default_nettype wire

>>> rtl/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd
// iterative binary gcd of two 64-bit magnitudes, one shift or subtract a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rau_gcd (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [rau_pkg::MAG_W-1:0] u_in,
    input  wire logic [rau_pkg::MAG_W-1:0] v_in,
    output logic                           done,
    output logic [rau_pkg::MAG_W-1:0]      g
);
    import rau_pkg::*;

    logic [MAG_W-1:0] u_reg, u_next;
    logic [MAG_W-1:0] v_reg, v_next;
    logic [6:0]       k_reg, k_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [MAG_W-1:0] g_reg, g_next;

    always_comb
    begin
        u_next    = u_reg;
        v_next    = v_reg;
        k_next    = k_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        g_next    = g_reg;
        if (start)
        begin
            u_next   = u_in;
            v_next   = v_in;
            k_next   = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (u_reg == '0)
            begin
                g_next    = v_reg << k_reg;
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else if (v_reg == '0)
            begin
                g_next    = u_reg << k_reg;
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else if (!u_reg[0] && !v_reg[0])
            begin
                u_next = u_reg >> 1;
                v_next = v_reg >> 1;
                k_next = k_reg + 7'd1;
            end
            else if (!u_reg[0])
                u_next = u_reg >> 1;
            else if (!v_reg[0])
                v_next = v_reg >> 1;
            else if (u_reg >= v_reg)
                u_next = u_reg - v_reg;
            else
                v_next = v_reg - u_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
        v_reg <= v_next;
        k_reg <= k_next;
        g_reg <= g_next;
    end

    assign done = done_reg;
    assign g    = g_reg;

endmodule

`default_nettype wire

>>> rtl/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div
// restoring 64-bit unsigned divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rau_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [rau_pkg::MAG_W-1:0] dividend,
    input  wire logic [rau_pkg::MAG_W-1:0] divisor,
    output logic                           done,
    output logic [rau_pkg::MAG_W-1:0]      quotient
);
    import rau_pkg::*;

    logic [MAG_W:0]   rem_reg, rem_next;
    logic [MAG_W-1:0] quo_reg, quo_next;
    logic [MAG_W-1:0] dvs_reg, dvs_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [MAG_W:0]   rem_sh;
    logic [MAG_W:0]   diff;

    always_comb
    begin
        rem_sh    = {rem_reg[MAG_W-1:0], quo_reg[MAG_W-1]};
        diff      = rem_sh - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = 7'(MAG_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = diff;
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> rtl/rau_mul.sv
// ----------------------------------------------------------------------------
// rau_mul
// registered signed 33x33 multiplier shared by all cross products
// ----------------------------------------------------------------------------
`default_nettype none

module rau_mul (
    input  wire logic                              clk,
    input  wire logic signed [rau_pkg::MUL_W-1:0]  x,
    input  wire logic signed [rau_pkg::MUL_W-1:0]  y,
    output logic signed [rau_pkg::PROD_W-1:0]      p
);
    import rau_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= x * y;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> rtl/rational_arithmetic_unit.sv
// operation steps: compare forms products and compares them; zero denominator and unused
// opcode go straight to the result; other operations form products (not negate and reduce),
// run a binary gcd and two divisions; a new transaction is taken the cycle after the result moves
// throughput: one transaction at a time, src_stall is high until the result
// is handed to the output register
// reset: control state clears asynchronously, the unit comes up idle
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// rational add, sub, mul, div, negate, reduce and compare with gcd reduction
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit #(
    parameter int VALUE_BITS = rau_pkg::VALUE_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              src_valid,
    output logic                   src_stall,
    input  wire rau_pkg::rau_in_t  src_data,
    output logic                   dst_valid,
    input  wire logic              dst_stall,
    output rau_pkg::rau_out_t      dst_data
);
    import rau_pkg::*;

    localparam logic [MAG_W-1:0] LIM = 64'd1 << (VALUE_BITS - 1);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_M1   = 10'b0000000010,
        S_M2   = 10'b0000000100,
        S_M3   = 10'b0000001000,
        S_M4   = 10'b0000010000,
        S_COMB = 10'b0000100000,
        S_GCD  = 10'b0001000000,
        S_DIVN = 10'b0010000000,
        S_DIVD = 10'b0100000000,
        S_FIN  = 10'b1000000000
    } state_t;

    state_t                   state_reg, state_next;
    rau_in_t                  op_reg, op_next;
    logic signed [PROD_W-1:0] t1_reg, t1_next;
    logic signed [PROD_W-1:0] t2_reg, t2_next;
    logic signed [PROD_W-1:0] t3_reg, t3_next;
    logic [MAG_W-1:0]         nm_reg, nm_next;
    logic [MAG_W-1:0]         dm_reg, dm_next;
    logic                     neg_reg, neg_next;
    logic [MAG_W-1:0]         g_reg, g_next;
    logic [MAG_W-1:0]         n_reg, n_next;
    rau_out_t                 res_reg, res_next;
    rau_out_t                 out_reg, out_next;
    logic                     vld_reg, vld_next;

    logic signed [MUL_W-1:0]  mx, my;
    logic signed [PROD_W-1:0] prod;
    logic signed [MUL_W-1:0]  an_x, ad_x, bn_x, bd_x, adabs_x;
    logic signed [PROD_W-1:0] num_s, den_s, lhs, rhs;
    logic [PROD_W-1:0]        num_a, den_a;
    logic                     zero_den;
    logic                     gcd_start, gcd_done;
    logic [MAG_W-1:0]         gcd_g;
    logic                     div_start, div_done;
    logic [MAG_W-1:0]         div_a, div_b, div_q;
    logic                     fneg, fits;

    rau_mul u_mul (
        .clk (clk),
        .x   (mx),
        .y   (my),
        .p   (prod)
    );

    rau_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .u_in  (nm_next),
        .v_in  (dm_next),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    rau_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    // operand extension and multiplier operand select
    always_comb
    begin
        an_x    = MUL_W'(op_reg.a_num);
        ad_x    = MUL_W'(op_reg.a_den);
        bn_x    = MUL_W'(op_reg.b_num);
        bd_x    = {2'b00, op_reg.b_den};
        adabs_x = op_reg.a_den[31] ? -ad_x : ad_x;
        mx      = an_x;
        my      = bd_x;
        case (state_reg)
            S_M1:
            begin
                mx = an_x;
                my = (op_reg.opcode == OP_MUL) ? bn_x : bd_x;
            end
            S_M2:
            begin
                if (op_reg.opcode == OP_MUL)
                begin
                    mx = ad_x;
                    my = bd_x;
                end
                else if (op_reg.opcode == OP_DIV)
                begin
                    mx = ad_x;
                    my = bn_x;
                end
                else
                begin
                    mx = bn_x;
                    my = (op_reg.opcode == OP_CMP) ? adabs_x : ad_x;
                end
            end
            S_M3:
            begin
                mx = ad_x;
                my = bd_x;
            end
            default:
            begin
                mx = an_x;
                my = bd_x;
            end
        endcase
    end

    always_comb
    begin
        zero_den = (src_data.a_den == '0)
            || ((src_data.opcode inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP})
                && (src_data.b_den == '0))
            || ((src_data.opcode == OP_DIV) && (src_data.b_num == '0));
    end

    // numerator and denominator before reduction
    always_comb
    begin
        lhs = op_reg.a_den[31] ? -t1_reg : t1_reg;
        rhs = t2_reg;
        case (op_reg.opcode)
            OP_ADD:
            begin
                num_s = t1_reg + t2_reg;
                den_s = t3_reg;
            end
            OP_SUB:
            begin
                num_s = t1_reg - t2_reg;
                den_s = t3_reg;
            end
            OP_MUL, OP_DIV:
            begin
                num_s = t1_reg;
                den_s = t2_reg;
            end
            OP_NEG:
            begin
                num_s = -PROD_W'(op_reg.a_num);
                den_s = PROD_W'(op_reg.a_den);
            end
            default:
            begin
                num_s = PROD_W'(op_reg.a_num);
                den_s = PROD_W'(op_reg.a_den);
            end
        endcase
        num_a = num_s[PROD_W-1] ? -num_s : num_s;
        den_a = den_s[PROD_W-1] ? -den_s : den_s;
    end

    // final range check on the reduced pair
    always_comb
    begin
        fneg = neg_reg && (n_reg != '0);
        fits = (div_q <= LIM - 64'd1)
            && (fneg ? (n_reg <= LIM) : (n_reg <= LIM - 64'd1));
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        t1_next    = t1_reg;
        t2_next    = t2_reg;
        t3_next    = t3_reg;
        nm_next    = nm_reg;
        dm_next    = dm_reg;
        neg_next   = neg_reg;
        g_next     = g_reg;
        n_next     = n_reg;
        res_next   = res_reg;
        out_next   = out_reg;
        vld_next   = vld_reg;
        gcd_start  = 1'b0;
        div_start  = 1'b0;
        div_a      = nm_reg;
        div_b      = gcd_g;

        if (vld_reg && !dst_stall)
            vld_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (src_valid)
                begin
                    op_next  = src_data;
                    res_next = '0;
                    if (src_data.opcode == OP_NOP)
                        state_next = S_FIN;
                    else if (zero_den)
                    begin
                        res_next.status = ST_ZERO_DEN;
                        state_next      = S_FIN;
                    end
                    else if (src_data.opcode inside {OP_NEG, OP_RED})
                        state_next = S_COMB;
                    else
                        state_next = S_M1;
                end
            end
            S_M1:
                state_next = S_M2;
            S_M2:
            begin
                t1_next    = prod;
                state_next = S_M3;
            end
            S_M3:
            begin
                t2_next    = prod;
                state_next = S_M4;
            end
            S_M4:
            begin
                t3_next    = prod;
                state_next = S_COMB;
            end
            S_COMB:
            begin
                if (op_reg.opcode == OP_CMP)
                begin
                    res_next.is_less  = (lhs < rhs);
                    res_next.is_equal = (lhs == rhs);
                    state_next        = S_FIN;
                end
                else
                begin
                    nm_next    = num_a[MAG_W-1:0];
                    dm_next    = den_a[MAG_W-1:0];
                    neg_next   = num_s[PROD_W-1] ^ den_s[PROD_W-1];
                    gcd_start  = 1'b1;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (gcd_done)
                begin
                    g_next     = gcd_g;
                    div_start  = 1'b1;
                    div_a      = nm_reg;
                    div_b      = gcd_g;
                    state_next = S_DIVN;
                end
            end
            S_DIVN:
            begin
                if (div_done)
                begin
                    n_next     = div_q;
                    div_start  = 1'b1;
                    div_a      = dm_reg;
                    div_b      = g_reg;
                    state_next = S_DIVD;
                end
            end
            S_DIVD:
            begin
                if (div_done)
                begin
                    res_next = '0;
                    if (fits)
                    begin
                        res_next.res_num = fneg ? -n_reg[31:0] : n_reg[31:0];
                        res_next.res_den = div_q[30:0];
                        res_next.status  = ST_OK;
                    end
                    else
                        res_next.status = ST_OVERFLOW;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // wait for the output register to free up
                if (!vld_reg || !dst_stall)
                begin
                    out_next   = res_reg;
                    vld_next   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        t1_reg  <= t1_next;
        t2_reg  <= t2_next;
        t3_reg  <= t3_next;
        nm_reg  <= nm_next;
        dm_reg  <= dm_next;
        neg_reg <= neg_next;
        g_reg   <= g_next;
        n_reg   <= n_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign src_stall = (state_reg != S_IDLE);
    assign dst_valid = vld_reg;
    assign dst_data  = out_reg;

endmodule

`default_nettype wire

>>> dv/rational_arithmetic_unit_tb.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// random and directed checking of the rational unit against a behavioral
// predictor, with both sides idling at random and a long output hold-off
// ----------------------------------------------------------------------------
`default_nettype none

class rau_scoreboard;
    rau_pkg::rau_out_t pending_results[$];
    int                errors;
    int                checked;

    // sign-magnitude product at double width
    static function void smul(input bit an, input logic [63:0] am, input bit bn,
                              input logic [63:0] bm, output bit rn,
                              output logic [63:0] rm);
        rm = am * bm;
        rn = (rm == 0) ? 1'b0 : (an ^ bn);
    endfunction

    static function void sadd(input bit an, input logic [63:0] am, input bit bn,
                              input logic [63:0] bm, output bit rn,
                              output logic [63:0] rm);
        if (an == bn)
        begin
            rn = an;
            rm = am + bm;
        end
        else if (am >= bm)
        begin
            rn = an;
            rm = am - bm;
        end
        else
        begin
            rn = bn;
            rm = bm - am;
        end
        if (rm == 0)
            rn = 1'b0;
    endfunction

    static function void split(input logic [31:0] v, output bit n,
                               output logic [63:0] m);
        n = v[31];
        m = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
    endfunction

    static function rau_pkg::rau_out_t rational_result(input rau_pkg::rau_in_t x);
        rau_pkg::rau_out_t r;
        bit                an, adn, bn, nn, dn, t1n, t2n, neg;
        logic [63:0]       am, adm, bm, bdm, nm, dm, t1m, t2m, g, a, b, q, n, d;
        r = '0;
        split(x.a_num, an, am);
        split(x.a_den, adn, adm);
        split(x.b_num, bn, bm);
        bdm = {33'd0, x.b_den};
        if (x.opcode == rau_pkg::OP_NOP)
            return r;
        if (adm == 0 || (x.opcode <= rau_pkg::OP_DIV && bdm == 0)
            || (x.opcode == rau_pkg::OP_CMP && bdm == 0)
            || (x.opcode == rau_pkg::OP_DIV && bm == 0))
        begin
            r.status = rau_pkg::ST_ZERO_DEN;
            return r;
        end
        case (x.opcode)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB:
            begin
                smul(an, am, 1'b0, bdm, t1n, t1m);
                smul(bn, bm, adn, adm, t2n, t2m);
                if (x.opcode == rau_pkg::OP_SUB && t2m != 0)
                    t2n = !t2n;
                sadd(t1n, t1m, t2n, t2m, nn, nm);
                smul(adn, adm, 1'b0, bdm, dn, dm);
            end
            rau_pkg::OP_MUL:
            begin
                smul(an, am, bn, bm, nn, nm);
                smul(adn, adm, 1'b0, bdm, dn, dm);
            end
            rau_pkg::OP_DIV:
            begin
                smul(an, am, 1'b0, bdm, nn, nm);
                smul(adn, adm, bn, bm, dn, dm);
            end
            rau_pkg::OP_NEG:
            begin
                nn = (am == 0) ? 1'b0 : !an;
                nm = am;
                dn = adn;
                dm = adm;
            end
            rau_pkg::OP_RED:
            begin
                nn = an;
                nm = am;
                dn = adn;
                dm = adm;
            end
            default:
            begin
                // scale both sides by |a_den| * b_den
                smul(an, am, 1'b0, bdm, t1n, t1m);
                if (adn && t1m != 0)
                    t1n = !t1n;
                smul(bn, bm, 1'b0, adm, t2n, t2m);
                if (t1n != t2n)
                    r.is_less = t1n;
                else
                    r.is_less = t1n ? (t1m > t2m) : (t1m < t2m);
                r.is_equal = (t1n == t2n) && (t1m == t2m);
                r.status = rau_pkg::ST_OK;
                return r;
            end
        endcase
        a = nm;
        b = dm;
        while (b != 0)
        begin
            g = a % b;
            a = b;
            b = g;
        end
        n = nm / a;
        d = dm / a;
        neg = (n == 0) ? 1'b0 : (nn ^ dn);
        if (d > 64'h7FFF_FFFF || (neg ? n > 64'h8000_0000 : n > 64'h7FFF_FFFF))
        begin
            r.status = rau_pkg::ST_OVERFLOW;
            return r;
        end
        q = neg ? (~n + 1) : n;
        r.res_num = q[31:0];
        r.res_den = d[30:0];
        r.status = rau_pkg::ST_OK;
        return r;
    endfunction

    function void note_operands(input rau_pkg::rau_in_t x);
        pending_results.push_back(rational_result(x));
    endfunction

    function void report(input string what, input logic [63:0] got,
                         input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
                 checked);
        errors++;
    endfunction

    function void check_result(input rau_pkg::rau_out_t y);
        rau_pkg::rau_out_t e;
        if (pending_results.size() == 0)
        begin
            $display("mismatch: result with nothing expected");
            errors++;
            return;
        end
        e = pending_results.pop_front();
        if (y.res_num !== e.res_num)
            report("res_num", y.res_num, e.res_num);
        if (y.res_den !== e.res_den)
            report("res_den", y.res_den, e.res_den);
        if (y.is_less !== e.is_less)
            report("is_less", y.is_less, e.is_less);
        if (y.is_equal !== e.is_equal)
            report("is_equal", y.is_equal, e.is_equal);
        if (y.status !== e.status)
            report("status", y.status, e.status);
        checked++;
    endfunction
endclass

module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic     clk;
    logic     rst_n;
    logic     src_valid;
    logic     src_stall;
    rau_in_t  src_data;
    logic     dst_valid;
    logic     dst_stall;
    rau_out_t dst_data;

    rau_scoreboard scb;
    int  src_idle_pct;
    int  dst_idle_pct;
    bit  hold_off;
    int  sent;
    int  quiet_cycles;
    int  op_count[8];

    rational_arithmetic_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] pick_value(input bit narrow);
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            4, 5: return $urandom();
            default: return narrow ? $urandom_range(0, 40) - 20 : $urandom_range(0, 2000) - 1000;
        endcase
    endfunction

    function automatic rau_in_t random_operands();
        rau_in_t x;
        x.opcode = 3'($urandom_range(0, 7));
        x.a_num = pick_value(1'($urandom_range(0, 1)));
        x.a_den = ($urandom_range(0, 9) == 0) ? pick_value(1'b1) : $urandom_range(1, 1000);
        if ($urandom_range(0, 7) == 0)
            x.a_den = $urandom();
        x.b_num = pick_value(1'($urandom_range(0, 1)));
        case ($urandom_range(0, 11))
            0: x.b_den = 31'd0;
            1: x.b_den = 31'h7FFF_FFFF;
            2, 3: x.b_den = 31'($urandom());
            default: x.b_den = 31'($urandom_range(1, 1000));
        endcase
        return x;
    endfunction

    // offer one transaction and wait for it to be taken
    task automatic send_operands(input rau_in_t x);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= x;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        scb.note_operands(x);
        op_count[x.opcode]++;
        sent++;
    endtask

    // withdraw the offer once a run of transactions is done
    task automatic stop_sending();
        src_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (scb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_directed(input logic [2:0] op, input logic [31:0] an,
                                 input logic [31:0] ad, input logic [31:0] bn,
                                 input logic [30:0] bd);
        rau_in_t x;
        x.opcode = op;
        x.a_num = an;
        x.a_den = ad;
        x.b_num = bn;
        x.b_den = bd;
        send_operands(x);
    endtask

    // result side: random stall, with an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dst_stall <= 1'b1;
        else
            dst_stall <= hold_off || ($urandom_range(0, 99) < dst_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && dst_valid && !dst_stall)
            scb.check_result(dst_data);
    end

    // watchdog on lack of progress
    always @(posedge clk)
    begin
        if (!rst_n || (src_valid && !src_stall) || (dst_valid && !dst_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int tail;
        scb = new();
        rst_n = 1'b0;
        src_valid = 1'b0;
        src_data = '0;
        hold_off = 1'b0;
        src_idle_pct = 0;
        dst_idle_pct = 0;
        sent = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send_directed(OP_ADD, 32'd1, 32'd2, 32'd1, 31'd3);
        send_directed(OP_SUB, 32'd1, 32'd2, 32'd1, 31'd2);
        send_directed(OP_MUL, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 31'd1);
        send_directed(OP_DIV, 32'd3, 32'd4, 32'hFFFF_FFFE, 31'd5);
        send_directed(OP_DIV, 32'd3, 32'd4, 32'd0, 31'd5);
        send_directed(OP_NEG, 32'h8000_0000, 32'd1, 32'd0, 31'd1);
        send_directed(OP_NEG, 32'h7FFF_FFFF, 32'd1, 32'd0, 31'd1);
        send_directed(OP_RED, 32'd6, 32'hFFFF_FFF7, 32'd0, 31'd0);
        send_directed(OP_RED, 32'd0, 32'h8000_0000, 32'd0, 31'd1);
        send_directed(OP_RED, 32'd5, 32'd0, 32'd0, 31'd1);
        send_directed(OP_ADD, 32'd1, 32'd3, 32'd1, 31'd0);
        send_directed(OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 31'd1);
        send_directed(OP_MUL, 32'd1, 32'h7FFF_FFFF, 32'd1, 31'h7FFF_FFFF);
        send_directed(OP_CMP, 32'd1, 32'd3, 32'd2, 31'd6);
        send_directed(OP_CMP, 32'hFFFF_FFFF, 32'd2, 32'd0, 31'd1);
        send_directed(OP_CMP, 32'd1, 32'hFFFF_FFFF, 32'd0, 31'd1);
        send_directed(OP_CMP, 32'd1, 32'd2, 32'd1, 31'd0);
        send_directed(OP_SUB, 32'd5, 32'd7, 32'd5, 31'd7);
        send_directed(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_directed(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
        stop_sending();

        // sender waits until the unit is empty
        drain();

        // long output hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (1500) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                repeat (6) send_operands(random_operands());
                stop_sending();
            end
        join

        for (phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 48 : 0;
            dst_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 15 : 0;
            repeat (225) send_operands(random_operands());
        end
        stop_sending();

        drain();
        tail = 0;
        while (tail < 400)
        begin
            @(posedge clk);
            tail++;
        end
        $display("sent %0d transactions, %0d results checked", sent, scb.checked);
        $display("per opcode add..nop: %0d %0d %0d %0d %0d %0d %0d %0d", op_count[0],
                 op_count[1], op_count[2], op_count[3], op_count[4], op_count[5],
                 op_count[6], op_count[7]);
        if (scb.errors == 0 && scb.pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire

>>> files.f
rtl/rau_pkg.sv
rtl/rau_gcd.sv
rtl/rau_div.sv
rtl/rau_mul.sv
rtl/rational_arithmetic_unit.sv
dv/rational_arithmetic_unit_tb.sv
